### hw/rtl/tah_pkg.sv
// Shared types, constants and helpers of the timestamp-aligned angle history block.
`default_nettype none
package tah_pkg;

    localparam int TIME_W = 48;
    localparam int ANG_W  = 32;
    localparam int ITW_W  = 24;
    localparam int CFG_W  = 48;

    localparam logic REG_INV_TRACK_WIDTH = 1'b0;
    localparam logic REG_FRESH_WINDOW    = 1'b1;

    localparam logic [ITW_W-1:0] ITW_RESET   = 24'd65536;
    localparam logic [TIME_W-1:0] FRESH_RESET = 48'd7000000;

    typedef struct packed {
        logic [TIME_W-1:0]       now_time;
        logic signed [ANG_W-1:0] turret_angle;
        logic                    drive_new;
        logic [TIME_W-1:0]       drive_time;
        logic signed [ANG_W-1:0] drive_left;
        logic signed [ANG_W-1:0] drive_right;
        logic                    vision_new;
        logic [TIME_W-1:0]       vision_target_time;
        logic signed [ANG_W-1:0] vision_angle;
    } in_item_t;

    typedef struct packed {
        logic signed [ANG_W-1:0] goal_angle;
        logic signed [ANG_W-1:0] target_absolute;
        logic                    vision_fresh;
    } out_item_t;

    typedef struct packed {
        logic [TIME_W-1:0]       stamp;
        logic signed [ANG_W-1:0] val;
    } hist_entry_t;

    // Saturate a wide signed value to the 32-bit angle range.
    function automatic logic signed [ANG_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = -64'sh0000_0000_8000_0000;
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[ANG_W-1:0];
    endfunction

endpackage
`default_nettype wire

### hw/rtl/tah_ring.sv
// Oldest-first history ring held in a synchronous memory with a registered read port.
`default_nettype none
module tah_ring #(
    parameter int DEPTH = 128,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push,
    input  tah_pkg::hist_entry_t push_data,
    input  wire [CW-1:0]         rd_idx,
    output tah_pkg::hist_entry_t rd_data,
    output logic [CW-1:0]        fill
);
    import tah_pkg::*;

    hist_entry_t      mem [DEPTH];
    logic [CW-1:0]    fill_reg;
    logic [AW-1:0]    head_reg;
    logic [CW:0]      wr_sum;
    logic [CW:0]      rd_sum;
    logic [AW-1:0]    wr_slot;
    logic [AW-1:0]    rd_slot;
    logic             full;
    hist_entry_t      rd_data_reg;

    assign full = (fill_reg == CW'(DEPTH));

    // Logical position to physical slot; the sum is always below twice the depth.
    always_comb
    begin
        wr_sum = (CW+1)'(head_reg) + (CW+1)'(full ? '0 : fill_reg);
        rd_sum = (CW+1)'(head_reg) + (CW+1)'(rd_idx);
        if (wr_sum >= (CW+1)'(DEPTH)) begin
            wr_sum = wr_sum - (CW+1)'(DEPTH);
        end
        if (rd_sum >= (CW+1)'(DEPTH)) begin
            rd_sum = rd_sum - (CW+1)'(DEPTH);
        end
        wr_slot = wr_sum[AW-1:0];
        rd_slot = rd_sum[AW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fill_reg <= '0;
            head_reg <= '0;
        end else if (push) begin
            if (full) begin
                head_reg <= (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
            end else begin
                fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem[wr_slot] <= push_data;
        end
        rd_data_reg <= mem[rd_slot];
    end

    assign rd_data = rd_data_reg;
    assign fill    = fill_reg;

endmodule
`default_nettype wire

### hw/rtl/tah_lookup.sv
// Bracket search over one ring followed by a serial divide and interpolation.
`default_nettype none
module tah_lookup #(
    parameter int DEPTH = 128,
    parameter int FB    = 16,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     start,
    input  wire [tah_pkg::TIME_W-1:0] t,
    input  wire [CW-1:0]            fill,
    output logic [CW-1:0]           rd_idx,
    input  tah_pkg::hist_entry_t    rd_data,
    output logic                    busy,
    output logic                    done,
    output logic signed [tah_pkg::ANG_W-1:0] res
);
    import tah_pkg::*;

    localparam int PW   = 35 + FB;
    localparam int CNTW = $clog2(FB + 1);

    localparam logic [2:0] L_IDLE = 3'd0;
    localparam logic [2:0] L_SCAN = 3'd1;
    localparam logic [2:0] L_PREP = 3'd2;
    localparam logic [2:0] L_DIV  = 3'd3;
    localparam logic [2:0] L_MUL  = 3'd4;
    localparam logic [2:0] L_SUM  = 3'd5;
    localparam logic [2:0] L_DONE = 3'd6;

    logic [2:0]              state_reg;
    logic [TIME_W-1:0]       t_reg;
    logic [CW-1:0]           idx_reg;
    hist_entry_t             prev_reg;
    hist_entry_t             a_reg;
    hist_entry_t             b_reg;
    logic [TIME_W-1:0]       den_reg;
    logic [TIME_W-1:0]       rem_reg;
    logic [FB:0]             ratio_reg;
    logic [CNTW-1:0]         cnt_reg;
    logic signed [PW-1:0]    prod_reg;
    logic signed [ANG_W-1:0] res_reg;

    logic                    found;
    logic                    neg;
    logic [TIME_W-1:0]       den;
    logic [TIME_W-1:0]       num;
    logic                    use_b;
    logic [TIME_W:0]         rem2;
    logic                    ge;
    logic signed [ANG_W:0]   vdiff;
    logic signed [PW:0]      sum;

    always_comb
    begin
        found  = (rd_data.stamp > t_reg);
        rd_idx = (state_reg == L_SCAN) ? idx_reg + 1'b1 : '0;
        neg    = (a_reg.stamp < b_reg.stamp);
        den    = neg ? b_reg.stamp - a_reg.stamp : a_reg.stamp - b_reg.stamp;
        num    = neg ? b_reg.stamp - t_reg : t_reg - b_reg.stamp;
        use_b  = (a_reg.stamp == b_reg.stamp) ||
                 (neg ? (t_reg >= b_reg.stamp) : (t_reg <= b_reg.stamp));
        rem2   = {rem_reg, 1'b0};
        ge     = (rem2 >= {1'b0, den_reg});
        vdiff  = (ANG_W+1)'(a_reg.val) - (ANG_W+1)'(b_reg.val);
        sum    = (PW+1)'(b_reg.val) + (PW+1)'(prod_reg >>> FB);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= L_IDLE;
        end else begin
            unique case (state_reg)
                L_IDLE: if (start) state_reg <= L_SCAN;
                L_SCAN: if (found || (idx_reg + 1'b1 == fill)) state_reg <= L_PREP;
                L_PREP:
                begin
                    if (use_b) begin
                        state_reg <= L_DONE;
                    end else if (num >= den) begin
                        state_reg <= L_MUL;
                    end else begin
                        state_reg <= L_DIV;
                    end
                end
                L_DIV:  if (cnt_reg == CNTW'(FB - 1)) state_reg <= L_MUL;
                L_MUL:  state_reg <= L_SUM;
                L_SUM:  state_reg <= L_DONE;
                // A new search may be started in the same cycle the result is handed over.
                L_DONE: state_reg <= start ? L_SCAN : L_IDLE;
                default: state_reg <= L_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            L_IDLE:
            begin
                t_reg   <= t;
                idx_reg <= '0;
            end
            L_SCAN:
            begin
                prev_reg <= rd_data;
                idx_reg  <= idx_reg + 1'b1;
                a_reg    <= rd_data;
                // The first sample past the target closes the bracket.
                b_reg    <= (found && idx_reg != '0) ? prev_reg : rd_data;
            end
            L_PREP:
            begin
                den_reg   <= den;
                rem_reg   <= num;
                cnt_reg   <= '0;
                res_reg   <= b_reg.val;
                ratio_reg <= (num >= den) ? (FB+1)'(1) << FB : '0;
            end
            L_DIV:
            begin
                rem_reg   <= ge ? TIME_W'(rem2 - {1'b0, den_reg}) : rem2[TIME_W-1:0];
                ratio_reg <= {ratio_reg[FB-1:0], ge};
                cnt_reg   <= cnt_reg + 1'b1;
            end
            L_MUL:  prod_reg <= PW'(vdiff * $signed({1'b0, ratio_reg}));
            L_SUM:  res_reg  <= sat32(64'(sum));
            L_DONE:
            begin
                t_reg   <= t;
                idx_reg <= '0;
            end
            default: ;
        endcase
    end

    assign busy = (state_reg != L_IDLE);
    assign done = (state_reg == L_DONE);
    assign res  = res_reg;

endmodule
`default_nettype wire

### hw/rtl/timestamp_aligned_angle_history.sv
// Top level: latency-compensated target angle from turret and heading histories.
// A drivetrain sample adds the heading multiply and saturate steps; vision, once a heading
// is stored, adds a lookup in the turret ring and then one in the heading ring.
// Throughput: one item at a time; the linear walk of each ring's memory port dominates.
// The next item is taken while a finished result still waits at the output register.
// Reset (asynchronous, active low) empties both rings and clears the target, heading
// and vision time; ring memories are not cleared because unfilled entries are never read.
`default_nettype none
module timestamp_aligned_angle_history #(
    parameter int HISTORY_DEPTH = 128,
    parameter int FRACTION_BITS = 16
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  tah_pkg::in_item_t      in_item,
    output logic                   out_valid,
    input  wire                    out_ready,
    output tah_pkg::out_item_t     out_item,
    input  wire                    cfg_we,
    input  wire                    cfg_index,
    input  wire [tah_pkg::CFG_W-1:0] cfg_data
);
    import tah_pkg::*;

    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int HW = 33 + 25;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HMUL = 3'd1;
    localparam logic [2:0] S_HSAT = 3'd2;
    localparam logic [2:0] S_VIS  = 3'd3;
    localparam logic [2:0] S_LKT  = 3'd4;
    localparam logic [2:0] S_LKH  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]              state_reg;
    in_item_t                item_reg;
    logic [ITW_W-1:0]        itw_reg;
    logic [TIME_W-1:0]       window_reg;
    logic signed [ANG_W-1:0] abs_reg;
    logic signed [ANG_W-1:0] latest_reg;
    logic [TIME_W-1:0]       last_vis_reg;
    logic signed [ANG_W-1:0] col_reg;
    logic signed [HW-1:0]    hprod_reg;
    logic                    sel_reg;
    logic                    out_valid_reg;
    out_item_t               out_reg;

    logic                    in_fire;
    logic                    t_push;
    logic                    h_push;
    hist_entry_t             t_push_data;
    hist_entry_t             h_push_data;
    logic signed [ANG_W-1:0] heading;
    logic [CW-1:0]           rd_idx;
    hist_entry_t             t_rd;
    hist_entry_t             h_rd;
    logic [CW-1:0]           t_fill;
    logic [CW-1:0]           h_fill;
    logic                    lk_start;
    logic                    lk_busy;
    logic                    lk_done;
    logic signed [ANG_W-1:0] lk_res;
    logic signed [ANG_W:0]   wheel_diff;
    logic [TIME_W:0]         fresh_end;
    logic                    out_load;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;

    // The turret sample goes into its ring at the very edge the item is taken.
    assign t_push      = in_fire;
    assign t_push_data = '{stamp: in_item.now_time, val: in_item.turret_angle};

    // Heading is the wheel difference times the reciprocal track width, floored.
    assign wheel_diff  = (ANG_W+1)'(item_reg.drive_right) - (ANG_W+1)'(item_reg.drive_left);
    assign heading     = sat32(64'(hprod_reg >>> FRACTION_BITS));
    assign h_push      = (state_reg == S_HSAT);
    assign h_push_data = '{stamp: item_reg.drive_time, val: heading};

    // Both lookups share one search engine; the turret ring is searched first.
    assign lk_start = (state_reg == S_VIS && item_reg.vision_new && h_fill != '0) ||
                      (state_reg == S_LKT && lk_done);

    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || out_ready);
    assign fresh_end = {1'b0, last_vis_reg} + {1'b0, window_reg};

    tah_ring #(.DEPTH(HISTORY_DEPTH)) u_turret_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (t_push),
        .push_data (t_push_data),
        .rd_idx    (rd_idx),
        .rd_data   (t_rd),
        .fill      (t_fill)
    );

    tah_ring #(.DEPTH(HISTORY_DEPTH)) u_heading_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (h_push),
        .push_data (h_push_data),
        .rd_idx    (rd_idx),
        .rd_data   (h_rd),
        .fill      (h_fill)
    );

    tah_lookup #(.DEPTH(HISTORY_DEPTH), .FB(FRACTION_BITS)) u_lookup (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (lk_start),
        .t       (item_reg.vision_target_time),
        .fill    (sel_reg ? h_fill : t_fill),
        .rd_idx  (rd_idx),
        .rd_data (sel_reg ? h_rd : t_rd),
        .busy    (lk_busy),
        .done    (lk_done),
        .res     (lk_res)
    );

    // Sequencer for one item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end else begin
            unique case (state_reg)
                S_IDLE: if (in_fire) state_reg <= in_item.drive_new ? S_HMUL : S_VIS;
                S_HMUL: state_reg <= S_HSAT;
                S_HSAT: state_reg <= S_VIS;
                S_VIS:  state_reg <= lk_start ? S_LKT : S_OUT;
                S_LKT:  if (lk_done) state_reg <= S_LKH;
                S_LKH:  if (lk_done) state_reg <= S_OUT;
                S_OUT:  if (out_load) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Architectural state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            itw_reg       <= ITW_RESET;
            window_reg    <= FRESH_RESET;
            abs_reg       <= '0;
            latest_reg    <= '0;
            last_vis_reg  <= '0;
            sel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_INV_TRACK_WIDTH: itw_reg    <= cfg_data[ITW_W-1:0];
                    REG_FRESH_WINDOW:    window_reg <= cfg_data[TIME_W-1:0];
                    default: ;
                endcase
            end
            if (h_push) begin
                latest_reg <= heading;
            end
            if (lk_start) begin
                sel_reg <= (state_reg == S_LKT);
            end
            if (state_reg == S_LKH && lk_done) begin
                abs_reg      <= sat32(64'(item_reg.vision_angle) + 64'(col_reg) + 64'(lk_res));
                last_vis_reg <= item_reg.now_time;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            item_reg <= in_item;
        end
        if (state_reg == S_HMUL) begin
            hprod_reg <= HW'(wheel_diff * $signed({1'b0, itw_reg}));
        end
        if (state_reg == S_LKT && lk_done) begin
            col_reg <= lk_res;
        end
        if (out_load) begin
            out_reg.goal_angle      <= sat32(64'(abs_reg) - 64'(latest_reg));
            out_reg.target_absolute <= abs_reg;
            out_reg.vision_fresh    <= ({1'b0, item_reg.now_time} < fresh_end);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // The search engine is never busy while a new item can be taken.
    assert property (@(posedge clk) disable iff (!rst_n) in_ready |-> !lk_busy)
        else $error("lookup busy while accepting");

    // Neither ring ever reports more entries than it holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (t_fill <= CW'(HISTORY_DEPTH)) && (h_fill <= CW'(HISTORY_DEPTH)))
        else $error("ring fill out of range");

    // A vision lookup is only started when the heading ring holds a sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        (lk_start && state_reg == S_VIS) |-> (h_fill != '0))
        else $error("lookup on empty heading ring");

    // An accepted item closes the input until its result has been produced.
    assert property (@(posedge clk) disable iff (!rst_n) in_fire |=> !in_ready)
        else $error("input reopened early");

endmodule
`default_nettype wire
